@@ sv/tks_pkg.sv @@
`default_nettype none

package tks_pkg;

    localparam int MAX_K_DEF  = 64;
    localparam int K_W        = 7;
    localparam int KEY_W      = 32;
    localparam int DOC_W      = 32;
    localparam int RANK_W     = 6;
    localparam int CNT_W      = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 104;
    localparam logic [K_W-1:0] K_RESET = K_W'(10);

    typedef enum logic
    {
        OP_OFFER = 1'b0,
        OP_FLUSH = 1'b1
    } tks_op_t;

    typedef enum logic
    {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } tks_state_t;

    typedef struct packed
    {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [DOC_W-1:0] doc;
    } tks_entry_t;

    typedef struct packed
    {
        logic insert;
        logic shift;
    } tks_cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/tks_cell.sv @@
`default_nettype none

module tks_cell
    import tks_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tks_cell_ctrl_t ctrl,
    input  wire logic [KEY_W-1:0] in_key,
    input  wire logic [DOC_W-1:0] in_doc,
    input  wire logic           in_range,
    input  wire logic           prev_beat,
    input  wire tks_entry_t     prev_ent,
    input  wire tks_entry_t     next_ent,
    output tks_entry_t          ent,
    output logic                beat
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [DOC_W-1:0] doc_reg;
    logic [DOC_W-1:0] doc_next;

    assign beat = !valid_reg || (in_key > key_reg);
    assign ent  = '{valid: valid_reg, key: key_reg, doc: doc_reg};

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        doc_next   = doc_reg;
        if (ctrl.shift)
        begin
            valid_next = next_ent.valid;
            key_next   = next_ent.key;
            doc_next   = next_ent.doc;
        end
        else if (ctrl.insert)
        begin
            if (prev_beat)
            begin
                valid_next = prev_ent.valid;
                key_next   = prev_ent.key;
                doc_next   = prev_ent.doc;
            end
            else if (beat)
            begin
                valid_next = 1'b1;
                key_next   = in_key;
                doc_next   = in_doc;
            end
        end
        valid_next = valid_next && in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        doc_reg <= doc_next;
    end

endmodule

`default_nettype wire

@@ sv/tks_drain.sv @@
`default_nettype none

module tks_drain
    import tks_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 offer_acc,
    input  wire logic                 flush_acc,
    input  wire tks_entry_t           head,
    input  wire logic                 head_next_valid,
    input  wire logic                 m_tready,
    output logic                      busy,
    output logic                      shift,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    tks_state_t        state_reg;
    tks_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  snap_reg;
    logic [CNT_W-1:0]  snap_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic              ovalid_reg;
    logic              ovalid_next;
    logic              load;
    logic              last;

    logic              evalid_reg;
    logic [KEY_W-1:0]  okey_reg;
    logic [DOC_W-1:0]  odoc_reg;
    logic [RANK_W-1:0] orank_reg;
    logic              olast_reg;
    logic [CNT_W-1:0]  ocnt_reg;

    assign last = !head.valid || !head_next_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (flush_acc)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy  = 1'b0;
        load  = 1'b0;
        shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_DRAIN:
            begin
                busy  = 1'b1;
                load  = !ovalid_reg || m_tready;
                shift = load;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        snap_next  = snap_reg;
        rank_next  = rank_reg;
        if (offer_acc && (count_reg != {CNT_W{1'b1}}))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (flush_acc)
        begin
            snap_next  = count_reg;
            count_next = '0;
            rank_next  = '0;
        end
        else if (load)
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
        ovalid_next = ovalid_reg;
        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            snap_reg   <= '0;
            rank_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            snap_reg   <= snap_next;
            rank_reg   <= rank_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evalid_reg <= head.valid;
            okey_reg   <= head.valid ? head.key : '0;
            odoc_reg   <= head.valid ? head.doc : '0;
            orank_reg  <= rank_reg;
            olast_reg  <= last;
            ocnt_reg   <= snap_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = evalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, ocnt_reg, orank_reg, odoc_reg, okey_reg};

`ifndef ASSERT_OFF
    a_shift_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> (state_reg == ST_DRAIN))
        else $error("chain shifted outside drain");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last) |=> (state_reg == ST_IDLE))
        else $error("drain did not end after last word");

    a_flush_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        flush_acc |=> (count_reg == '0) && (rank_reg == '0))
        else $error("flush did not clear counters");

    a_rank_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !last) |=> (rank_reg == $past(rank_reg) + RANK_W'(1)))
        else $error("rank did not advance");
`endif

endmodule

`default_nettype wire

@@ sv/top_k_score_selector_top.sv @@
// channel  | dir | tdata (low bit up)                          | tuser         | tlast
// s_axis   | in  | score_key[31:0] document[63:32]             | opcode        | -
// m_axis   | out | out_score, out_document, rank, matches_seen | entry_valid   | last_entry
// k_in_use | in  | k_in_use_we / k_in_use_wdata, 7 bits        | -             | -
//
// Offers are accepted back to back while idle.
// A flush drains the cell chain one entry per cycle unless the output stalls, emitting
// max(1, kept) words; s_axis_tready stays low until the last word is loaded.
// The ordered insert compares the new key against every cell at once.
// Reset clears all cells, the match counter and sets k_in_use to 10.
`default_nettype none

module top_k_score_selector_top
    import tks_pkg::*;
#(
    parameter int MAX_K = MAX_K_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 k_in_use_we,
    input  wire logic [K_W-1:0]       k_in_use_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // score_key, document
    input  wire logic                 s_axis_tuser,  // opcode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // out_score, out_document, rank,
                                                     // matches_seen, 2 pad bits
    output logic                      m_axis_tuser,  // entry_valid
    output logic                      m_axis_tlast   // last_entry
);

    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   cap;
    logic [KEY_W-1:0] in_key;
    logic [DOC_W-1:0] in_doc;
    logic             accept;
    logic             offer_acc;
    logic             flush_acc;
    logic             busy;
    logic             shift;
    logic             head_next_valid;
    tks_cell_ctrl_t   ctrl;
    tks_entry_t       ents  [MAX_K];
    logic             beats [MAX_K];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (k_in_use_we)
        begin
            k_reg <= k_in_use_wdata;
        end
    end

    assign cap = (k_reg > K_W'(MAX_K)) ? K_W'(MAX_K) : k_reg;

    assign in_key        = s_axis_tdata[KEY_W-1:0];
    assign in_doc        = s_axis_tdata[KEY_W+DOC_W-1:KEY_W];
    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign offer_acc     = accept && (tks_op_t'(s_axis_tuser) == OP_OFFER);
    assign flush_acc     = accept && (tks_op_t'(s_axis_tuser) == OP_FLUSH);
    assign ctrl          = '{insert: offer_acc && (in_key != '0), shift: shift};

    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        tks_entry_t pent;
        tks_entry_t nent;
        logic       pbeat;
        logic       rng;

        if (i == 0)
        begin : g_first
            assign pent  = '0;
            assign pbeat = 1'b0;
        end
        else
        begin : g_mid
            assign pent  = ents[i-1];
            assign pbeat = beats[i-1];
        end

        if (i == MAX_K - 1)
        begin : g_last
            assign nent = '0;
        end
        else
        begin : g_body
            assign nent = ents[i+1];
        end

        assign rng = (K_W'(i) < cap);

        tks_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_key    (in_key),
            .in_doc    (in_doc),
            .in_range  (rng),
            .prev_beat (pbeat),
            .prev_ent  (pent),
            .next_ent  (nent),
            .ent       (ents[i]),
            .beat      (beats[i])
        );
    end

    if (MAX_K > 1)
    begin : g_nv
        assign head_next_valid = ents[1].valid;
    end
    else
    begin : g_nv1
        assign head_next_valid = 1'b0;
    end

    tks_drain u_drain
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .offer_acc       (offer_acc),
        .flush_acc       (flush_acc),
        .head            (ents[0]),
        .head_next_valid (head_next_valid),
        .m_tready        (m_axis_tready),
        .busy            (busy),
        .shift           (shift),
        .m_tvalid        (m_axis_tvalid),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .m_tlast         (m_axis_tlast)
    );

endmodule

`default_nettype wire
